FILE: rtl/cmrg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cmrg_pkg;

   localparam int NUM_STREAMS_DEFAULT = 1024;

   localparam logic [30:0] MOD1 = 31'd2147483647;
   localparam logic [30:0] MOD2 = 31'd2145483479;
   // 2^31 - MOD2, used to fold the upper bits of a product back below 2^31
   localparam logic [20:0] M2_FOLD = 21'd2000169;

   localparam logic [19:0] COEF_A12 = 20'd63308;
   localparam logic [19:0] COEF_A13 = 20'd183326;
   localparam logic [19:0] COEF_A21 = 20'd86098;
   localparam logic [19:0] COEF_A23 = 20'd539608;

   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   typedef struct packed {
      logic        command;
      logic [9:0]  stream_index;
      logic [30:0] seed_a0;
      logic [30:0] seed_a1;
      logic [30:0] seed_a2;
      logic [30:0] seed_b0;
      logic [30:0] seed_b1;
      logic [30:0] seed_b2;
   } req_type;

   typedef struct packed {
      logic [30:0] sample;
      logic [9:0]  sample_stream;
   } rsp_type;

   typedef struct packed {
      logic [30:0] first_oldest;
      logic [30:0] first_middle;
      logic [30:0] first_newest;
      logic [30:0] second_oldest;
      logic [30:0] second_middle;
      logic [30:0] second_newest;
   } hist_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_READ,
      ST_MUL,
      ST_RED1,
      ST_RED2,
      ST_RED3,
      ST_RED4,
      ST_SUBM,
      ST_COMB
   } state_type;

   typedef struct packed {
      logic capture;
      logic write_seed;
      logic write_back;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_load;
      logic req_in_range;
   } ctrl_status_type;

endpackage

`default_nettype wire

FILE: rtl/combined_mrg_stream_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Bank of combined multiple-recursive generators, one history pair per stream.
// Input: req_item is taken at a rising edge where start is high and busy is low.
//   A load writes the six seed words of the stream and gives no result.
//   A draw advances both components of the stream and gives one result.
//   A stream index at or above NUM_STREAMS is dropped without a result.
// Output: rsp_strobe is high for exactly one cycle with rsp_item; the receiver
//   takes the beat in that cycle and cannot stall it.
// Timing: busy drops in the same cycle in which a draw shows its result, so the
//   block takes no new request until the previous one is through. A draw passes
//   through the registered history memory read, the coefficient multipliers and
//   the four-step modular fold that reduces each product, then the two subtract
//   stages.
// Reset: the controller returns to idle and no strobe is issued. The stored
//   histories are not cleared; a stream must be loaded before it is drawn.

module combined_mrg_stream_generator_top import cmrg_pkg::*; #(
   parameter int NUM_STREAMS = NUM_STREAMS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   cmrg_control u_control (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   cmrg_datapath #(
      .NUM_STREAMS (NUM_STREAMS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

FILE: rtl/cmrg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cmrg_datapath import cmrg_pkg::*; #(
   parameter int NUM_STREAMS = NUM_STREAMS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  req_type         req_item,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   output logic            rsp_strobe,
   output rsp_type         rsp_item
);

   localparam int AddrWidth = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

   hist_type hist_mem [NUM_STREAMS];

   req_type                req_ff;
   hist_type               rd_ff;
   hist_type               wr_data;
   logic [AddrWidth-1:0]   addr;

   // lanes 0 and 1 reduce modulo MOD1, lanes 2 and 3 modulo MOD2
   logic [19:0] coef   [4];
   logic [30:0] word   [4];
   logic [20:0] fold_k [4];
   logic [30:0] modv   [4];

   logic [50:0] prod_in [4];
   logic [50:0] prod_ff [4];
   logic [41:0] r1_in   [4];
   logic [41:0] r1_ff   [4];
   logic [31:0] r2_in   [4];
   logic [31:0] r2_ff   [4];
   logic [31:0] r3_in   [4];
   logic [31:0] r3_ff   [4];
   logic [30:0] r4_in   [4];
   logic [30:0] r4_ff   [4];

   logic [30:0] x1_in, x1_ff;
   logic [30:0] x2_in, x2_ff;
   logic [30:0] diff;
   logic [30:0] z_in, z_ff;
   logic        strobe_ff;

   assign status.req_load     = (req_item.command == CMD_LOAD);
   assign status.req_in_range = (int'(req_item.stream_index) < NUM_STREAMS);

   assign addr = AddrWidth'(req_ff.stream_index);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
   end

   always_comb begin
      if (cmd.write_seed) begin
         wr_data.first_oldest  = req_ff.seed_a0;
         wr_data.first_middle  = req_ff.seed_a1;
         wr_data.first_newest  = req_ff.seed_a2;
         wr_data.second_oldest = req_ff.seed_b0;
         wr_data.second_middle = req_ff.seed_b1;
         wr_data.second_newest = req_ff.seed_b2;
      end else begin
         // shift both histories by one word
         wr_data.first_oldest  = rd_ff.first_middle;
         wr_data.first_middle  = rd_ff.first_newest;
         wr_data.first_newest  = x1_ff;
         wr_data.second_oldest = rd_ff.second_middle;
         wr_data.second_middle = rd_ff.second_newest;
         wr_data.second_newest = x2_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= hist_mem[addr];
      if (cmd.write_seed || cmd.write_back) begin
         hist_mem[addr] <= wr_data;
      end
   end

   assign coef[0] = COEF_A12;
   assign coef[1] = COEF_A13;
   assign coef[2] = COEF_A21;
   assign coef[3] = COEF_A23;

   assign word[0] = rd_ff.first_middle;
   assign word[1] = rd_ff.first_oldest;
   assign word[2] = rd_ff.second_newest;
   assign word[3] = rd_ff.second_oldest;

   assign fold_k[0] = 21'd1;
   assign fold_k[1] = 21'd1;
   assign fold_k[2] = M2_FOLD;
   assign fold_k[3] = M2_FOLD;

   assign modv[0] = MOD1;
   assign modv[1] = MOD1;
   assign modv[2] = MOD2;
   assign modv[3] = MOD2;

   // fold the bits above 2^31 back in three times, then one conditional subtract
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = 51'(coef[i]) * 51'(word[i]);
         r1_in[i]   = 42'(prod_ff[i][50:31]) * 42'(fold_k[i]) + 42'(prod_ff[i][30:0]);
         r2_in[i]   = 32'(r1_ff[i][41:31]) * 32'(fold_k[i]) + 32'(r1_ff[i][30:0]);
         r3_in[i]   = r2_ff[i][31] ? (32'(fold_k[i]) + 32'(r2_ff[i][30:0]))
                                   : 32'(r2_ff[i][30:0]);
         r4_in[i]   = (r3_ff[i] >= 32'(modv[i])) ? 31'(r3_ff[i] - 32'(modv[i]))
                                                 : r3_ff[i][30:0];
      end
   end

   always_comb begin
      x1_in = (r4_ff[0] >= r4_ff[1]) ? (r4_ff[0] - r4_ff[1])
                                     : 31'(32'(r4_ff[0]) + 32'(MOD1) - 32'(r4_ff[1]));
      x2_in = (r4_ff[2] >= r4_ff[3]) ? (r4_ff[2] - r4_ff[3])
                                     : 31'(32'(r4_ff[2]) + 32'(MOD2) - 32'(r4_ff[3]));
      diff  = (x1_ff >= x2_ff) ? (x1_ff - x2_ff)
                               : 31'(32'(x1_ff) + 32'(MOD1) - 32'(x2_ff));
      z_in  = (diff == 31'd0) ? MOD1 : diff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         prod_ff[i] <= prod_in[i];
         r1_ff[i]   <= r1_in[i];
         r2_ff[i]   <= r2_in[i];
         r3_ff[i]   <= r3_in[i];
         r4_ff[i]   <= r4_in[i];
      end
      x1_ff <= x1_in;
      x2_ff <= x2_in;
      z_ff  <= z_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   assign rsp_strobe             = strobe_ff;
   assign rsp_item.sample        = z_ff;
   assign rsp_item.sample_stream = req_ff.stream_index;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("result strobe held for two cycles");

endmodule

`default_nettype wire

FILE: rtl/cmrg_control.sv
`timescale 1ns / 1ps
`default_nettype none

module cmrg_control import cmrg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  ctrl_status_type status,
   output logic            busy,
   output ctrl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               if (!status.req_in_range) begin
                  state_in = ST_IDLE;
               end else if (status.req_load) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_LOAD: begin
            cmd.write_seed = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_READ: state_in = ST_MUL;
         ST_MUL:  state_in = ST_RED1;
         ST_RED1: state_in = ST_RED2;
         ST_RED2: state_in = ST_RED3;
         ST_RED3: state_in = ST_RED4;
         ST_RED4: state_in = ST_SUBM;
         ST_SUBM: state_in = ST_COMB;
         ST_COMB: begin
            cmd.write_back = 1'b1;
            cmd.emit       = 1'b1;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   a_draw_emits: assert property (@(posedge clock) disable iff (reset)
      start && !busy && status.req_in_range && !status.req_load |-> ##8 cmd.emit)
      else $error("draw did not produce a result on time");

   a_load_writes: assert property (@(posedge clock) disable iff (reset)
      start && !busy && status.req_in_range && status.req_load |=> cmd.write_seed)
      else $error("load did not write the seed words");

   a_skip_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !status.req_in_range |=> !busy)
      else $error("out-of-range stream index did not return to idle");

endmodule

`default_nettype wire
